>>> design/bounded_circular_deque_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded circular deque
// Shared property forms used by the deque's port checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_CIRCULAR_DEQUE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCDQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("deque check failed");

// Consequent must hold in the cycle after the antecedent.
`define BCDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("deque check failed");

`endif

>>> design/bcdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded circular deque package
// Shared types and constants for the deque cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcdq_pkg;

    localparam int BCDQ_DEPTH     = 16;
    localparam int CAP_W          = 5;
    localparam int WORD_W         = 32;
    localparam int REQ_W          = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STATUS     = 3'd4;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word EMPTY_WORD = '1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_SHIFT_FRONT,
        CELL_LOAD_TAIL
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_word    value;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } t_state;

endpackage

>>> design/bcdq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the deque chain: shifts toward either neighbor, loads a new
// tail word, and presents its word when it holds the rear entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcdq_cell
    import bcdq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  t_word         i_left_data,
    input  t_word         i_right_data,
    input  logic [CW-1:0] i_count,
    output t_word         o_data,
    output t_word         o_rear_data
);

    localparam logic [CW-1:0] SLOT = CW'(IDX);
    localparam logic [CW-1:0] MARK = CW'(IDX + 1);

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_SHIFT_BACK:  n_data = i_left_data;
            CELL_SHIFT_FRONT: n_data = i_right_data;
            CELL_LOAD_TAIL: begin
                // Only the first unoccupied slot takes the pushed word.
                if (i_count == SLOT) begin
                    n_data = i_ctl.value;
                end
            end
            CELL_HOLD:        n_data = r_data;
            default:          n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_rear_data = (i_count == MARK) ? r_data : '0;

endmodule

>>> design/bounded_circular_deque_top.sv
// ----------------------------------------------------------------------------
// Bounded circular deque
// Each request is one input word (request type and push value); each
// request gives one result word with the accepted flag, the front and rear
// values (-1 when empty) and the empty and full flags after the request.
// The entries sit in a row of DEPTH cells, front entry in the first cell;
// pushes and pops at the front shift the whole row by one place, a push at
// the back loads the first free cell, and a pop at the back only lowers the
// count. The capacity register (i_cfg_we, i_cfg_data) limits the count to
// min(capacity, DEPTH); the user must see that it is written only while the
// deque is idle, and the block itself does not enforce this. An accepted
// request moves the control from ST_IDLE to ST_REPORT, where its result is
// loaded into the output register once that register is free; o_stall is
// high in ST_REPORT, so no new request is taken until that result is loaded.
// A result waiting under i_stall does not stop the next request from being
// taken; only the result of that next request waits for the register.
// Reset empties the deque (count cleared, cells kept) and sets capacity 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_circular_deque_top
    import bcdq_pkg::*;
#(
    parameter int DEPTH = BCDQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_word            i_push_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_accepted,
    output t_word            o_front_value,
    output t_word            o_rear_value,
    output logic             o_is_empty,
    output logic             o_is_full,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CAP_W-1:0] r_capacity;
    logic             r_ok;
    logic             n_ok;

    logic  r_ovalid;
    logic  r_accepted;
    t_word r_front;
    t_word r_rear;
    logic  r_empty;
    logic  r_full;

    logic      w_accept;
    logic      w_out_free;
    logic      w_load_out;
    logic      w_full;
    logic      w_empty;
    logic [MW-1:0] w_cap_eff;
    t_cell_ctl w_ctl;
    t_word     w_rear_or;

    t_word w_data [DEPTH];
    t_word w_rear [DEPTH];

    // Effective capacity is the register clipped to the row length.
    assign w_cap_eff = (MW'(r_capacity) > MW'(DEPTH)) ? MW'(DEPTH) : MW'(r_capacity);
    assign w_full    = MW'(r_count) >= w_cap_eff;
    assign w_empty   = (r_count == '0);

    assign w_out_free = !r_ovalid || !i_stall;
    assign w_accept   = i_valid && !o_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_stall    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                w_load_out = 1'b0;
            end
            ST_REPORT: begin
                o_stall    = 1'b1;
                w_load_out = w_out_free;
            end
            default: begin
                o_stall    = 1'b1;
                w_load_out = 1'b0;
            end
        endcase
    end

    // Request decode: a refused request leaves the cells and count alone.
    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.value = i_push_value;
        n_count     = r_count;
        n_ok        = 1'b0;
        case (i_req_type)
            REQ_PUSH_FRONT: begin
                if (!w_full) begin
                    w_ctl.op = CELL_SHIFT_BACK;
                    n_count  = r_count + 1'b1;
                    n_ok     = 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (!w_full) begin
                    w_ctl.op = CELL_LOAD_TAIL;
                    n_count  = r_count + 1'b1;
                    n_ok     = 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (!w_empty) begin
                    w_ctl.op = CELL_SHIFT_FRONT;
                    n_count  = r_count - 1'b1;
                    n_ok     = 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (!w_empty) begin
                    n_count = r_count - 1'b1;
                    n_ok    = 1'b1;
                end
            end
            REQ_STATUS: n_ok = 1'b1;
            default:    n_ok = 1'b0;
        endcase
        if (!w_accept) begin
            w_ctl.op = CELL_HOLD;
            n_count  = r_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_word w_left;
            t_word w_right;
            if (g == 0) begin : g_first
                assign w_left = i_push_value;
            end else begin : g_mid_left
                assign w_left = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_right
                assign w_right = w_data[g+1];
            end
            bcdq_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .i_count      (r_count),
                .o_data       (w_data[g]),
                .o_rear_data  (w_rear[g])
            );
        end
    endgenerate

    // Only the rear cell drives a nonzero word, so an OR picks it out.
    always_comb begin
        w_rear_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear_or = w_rear_or | w_rear[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_capacity <= CAP_RESET;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok <= n_ok;
        end
        if (w_load_out) begin
            r_accepted <= r_ok;
            r_empty    <= w_empty;
            r_full     <= w_full;
            r_front    <= w_empty ? EMPTY_WORD : w_data[0];
            r_rear     <= w_empty ? EMPTY_WORD : w_rear_or;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_accepted    = r_accepted;
    assign o_front_value = r_front;
    assign o_rear_value  = r_rear;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;

endmodule

>>> design/bcdq_checker.sv
// ----------------------------------------------------------------------------
// Deque port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_circular_deque_top_assert.svh"

module bcdq_checker
    import bcdq_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_valid,
    input logic  o_stall,
    input logic  o_valid,
    input logic  i_stall,
    input logic  o_accepted,
    input t_word o_front_value,
    input t_word o_rear_value,
    input logic  o_is_empty,
    input logic  o_is_full
);

    logic                   w_ends_marked;
    logic [2*WORD_W+2:0]    w_out_word;

    assign w_ends_marked = (o_front_value == EMPTY_WORD) && (o_rear_value == EMPTY_WORD);
    assign w_out_word    = {o_accepted, o_front_value, o_rear_value, o_is_empty, o_is_full};

    // An empty deque reports the marker word at both ends.
    `BCDQ_ASSERT_SAME(a_empty_marker, o_valid && o_is_empty, w_ends_marked)

    // Requests are taken one at a time.
    `BCDQ_ASSERT_NEXT(a_one_in_flight, i_valid && !o_stall, o_stall)

    // A pending request frees the input once the output can take its word.
    `BCDQ_ASSERT_NEXT(a_release, o_stall && !i_stall, !o_stall)

    // A stalled result word holds.
    `BCDQ_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_out_word))

endmodule

bind bounded_circular_deque_top bcdq_checker u_bcdq_checker (.*);

>>> sim/bounded_circular_deque_top_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the bounded circular deque
// Drives request words through the valid/stall input channel and checks every
// result word against a mirror of the deque's ring store, front index, count
// and capacity register. The run starts with directed requests covering the
// edge cases, then moves through random phases at several capacity settings
// with random idling on both channels, a long output hold-off and a final
// stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_circular_deque_top_tb;
    import bcdq_pkg::*;

    localparam int IDX_W = $clog2(BCDQ_DEPTH);
    localparam logic [REQ_W-1:0] REQ_LAST_CODE = '1;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASES = 8;

    typedef struct packed {
        logic  accepted;
        t_word front_value;
        t_word rear_value;
        logic  is_empty;
        logic  is_full;
    } t_deque_status;

    class deque_mirror;
        t_word            ring[BCDQ_DEPTH];
        logic [IDX_W-1:0] head;
        logic [CAP_W-1:0] count;
        logic [CAP_W-1:0] capacity;
        t_deque_status    expected_status[$];
        int unsigned      mismatches;

        function new();
            head = '0;
            count = '0;
            capacity = CAP_RESET;
            mismatches = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function int unsigned pending();
            return expected_status.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] req, t_word val);
            t_deque_status    s;
            logic [CAP_W-1:0] limit;
            logic [CAP_W-1:0] last;
            logic [IDX_W-1:0] slot;
            logic             full_now;
            limit = (capacity > CAP_W'(BCDQ_DEPTH)) ? CAP_W'(BCDQ_DEPTH) : capacity;
            full_now = (count >= limit);
            s = '0;
            case (req)
                REQ_PUSH_FRONT: begin
                    if (!full_now) begin
                        head = head - 1'b1;
                        ring[head] = val;
                        count = count + 1'b1;
                        s.accepted = 1'b1;
                    end
                end
                REQ_PUSH_BACK: begin
                    if (!full_now) begin
                        slot = head + count[IDX_W-1:0];
                        ring[slot] = val;
                        count = count + 1'b1;
                        s.accepted = 1'b1;
                    end
                end
                REQ_POP_FRONT: begin
                    if (count != 0) begin
                        head = head + 1'b1;
                        count = count - 1'b1;
                        s.accepted = 1'b1;
                    end
                end
                REQ_POP_BACK: begin
                    if (count != 0) begin
                        count = count - 1'b1;
                        s.accepted = 1'b1;
                    end
                end
                REQ_STATUS: s.accepted = 1'b1;
                // The unused codes only report status and are not accepted.
                default: s.accepted = 1'b0;
            endcase
            s.is_empty = (count == 0);
            s.is_full = (count >= limit);
            if (s.is_empty) begin
                s.front_value = EMPTY_WORD;
                s.rear_value = EMPTY_WORD;
            end else begin
                last = count - 1'b1;
                slot = head + last[IDX_W-1:0];
                s.front_value = ring[head];
                s.rear_value = ring[slot];
            end
            expected_status.push_back(s);
        endfunction

        task report_mismatch(string what, t_word want, t_word got);
            mismatches++;
            $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
        endtask

        task check_status(t_deque_status got);
            t_deque_status want;
            if (expected_status.size() == 0) begin
                report_mismatch("result word with no request pending", '0, got.front_value);
                return;
            end
            want = expected_status.pop_front();
            if (got.accepted !== want.accepted)
                report_mismatch("accepted", want.accepted, got.accepted);
            if (got.front_value !== want.front_value)
                report_mismatch("front_value", want.front_value, got.front_value);
            if (got.rear_value !== want.rear_value)
                report_mismatch("rear_value", want.rear_value, got.rear_value);
            if (got.is_empty !== want.is_empty)
                report_mismatch("is_empty", want.is_empty, got.is_empty);
            if (got.is_full !== want.is_full)
                report_mismatch("is_full", want.is_full, got.is_full);
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [REQ_W-1:0] i_req_type;
    t_word            i_push_value;
    logic             o_valid;
    logic             i_stall;
    logic             o_accepted;
    t_word            o_front_value;
    t_word            o_rear_value;
    logic             o_is_empty;
    logic             o_is_full;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_data;

    deque_mirror mirror;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    logic        quiet_tail = 1'b0;

    bounded_circular_deque_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_accepted    (o_accepted),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Both channels are observed at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            mirror.note_request(i_req_type, i_push_value);
        if (i_rst_n && o_valid && !i_stall)
            mirror.check_status({o_accepted, o_front_value, o_rear_value, o_is_empty, o_is_full});
    end

    // Output side: random stall bursts, plus a long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall = 1'b0;
                holds_served++;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("[bounded_circular_deque_top] ERROR");
        $finish;
    end

    function automatic t_word pick_value();
        case ($urandom_range(0, 9))
            0: return t_word'(32'h8000_0000);
            1: return t_word'(32'h7fff_ffff);
            2: return EMPTY_WORD;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(int unsigned push_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        if (roll < 94)
            return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        if (roll < 97)
            return REQ_STATUS;
        return REQ_LAST_CODE - REQ_W'($urandom_range(0, 2));
    endfunction

    function automatic int unsigned sender_gap();
        if (quiet_tail || $urandom_range(0, 7) != 0)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [REQ_W-1:0] req, input t_word val,
                             input int unsigned gap);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_req_type = req;
        i_push_value = val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (mirror.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        mirror.capacity = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] cap_plan[PHASES];
        int unsigned      phase_items;
        int unsigned      push_pct;
        int unsigned      seg_left;

        mirror = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_STATUS;
        i_push_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = CAP_RESET;
        push_pct = 50;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty queue, refused pops, extreme values and the unused codes.
        send_word(REQ_STATUS, pick_value(), 0);
        send_word(REQ_POP_FRONT, pick_value(), 0);
        send_word(REQ_POP_BACK, pick_value(), 0);
        send_word(REQ_PUSH_FRONT, t_word'(32'h7fff_ffff), 0);
        send_word(REQ_PUSH_BACK, t_word'(32'h8000_0000), 0);
        send_word(REQ_PUSH_FRONT, EMPTY_WORD, 0);
        send_word(REQ_PUSH_BACK, '0, 0);
        for (int c = REQ_STATUS + 1; c <= REQ_LAST_CODE; c++)
            send_word(REQ_W'(c), pick_value(), 0);
        send_word(REQ_POP_BACK, pick_value(), 0);
        send_word(REQ_POP_FRONT, pick_value(), 0);
        send_word(REQ_POP_FRONT, pick_value(), 0);
        send_word(REQ_POP_BACK, pick_value(), 0);

        // With zero capacity every push is refused and the queue is both empty and full.
        wait_idle();
        write_capacity('0);
        send_word(REQ_PUSH_FRONT, pick_value(), 0);
        send_word(REQ_PUSH_BACK, pick_value(), 0);
        send_word(REQ_STATUS, pick_value(), 0);

        wait_idle();
        write_capacity(CAP_W'(3));
        send_word(REQ_PUSH_BACK, EMPTY_WORD, 0);
        send_word(REQ_PUSH_BACK, t_word'(32'h8000_0000), 0);
        send_word(REQ_PUSH_FRONT, t_word'($urandom), 0);
        send_word(REQ_PUSH_FRONT, t_word'($urandom), 0);

        // Capacity dropped under the count: held entries stay, full until drained below it.
        wait_idle();
        write_capacity(CAP_W'(1));
        send_word(REQ_PUSH_BACK, pick_value(), 0);
        send_word(REQ_POP_FRONT, pick_value(), 0);
        send_word(REQ_POP_BACK, pick_value(), 0);
        send_word(REQ_POP_FRONT, pick_value(), 0);

        cap_plan = '{5'd31, 5'd1, 5'd0, 5'd7, 5'd17, 5'd16, 5'd2, 5'd16};
        cap_plan[5] = CAP_W'($urandom_range(0, 16));
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_capacity(cap_plan[p]);
            quiet_tail = (p == PHASES - 1);
            phase_items = (cap_plan[p] == 0) ? 40 : 200;
            seg_left = 0;
            for (int n = 0; n < phase_items; n++) begin
                // Push-heavy and pop-heavy stretches walk the count between empty and full.
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 50);
                    case ($urandom_range(0, 2))
                        0: push_pct = 25;
                        1: push_pct = 50;
                        default: push_pct = 80;
                    endcase
                end
                seg_left--;
                if (p == 0 && n == 100) begin
                    hold_requests++;
                    repeat (40) send_word(pick_request(80), pick_value(), 0);
                end
                if (p == 0 && n == 150)
                    wait_idle();
                send_word(pick_request(push_pct), pick_value(), sender_gap());
            end
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("[bounded_circular_deque_top] OK");
        end else begin
            $display("[bounded_circular_deque_top] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bcdq_pkg.sv
design/bcdq_cell.sv
design/bounded_circular_deque_top.sv
design/bcdq_checker.sv
sim/bounded_circular_deque_top_tb.sv
